// ===== rtl/erm_pkg.sv =====
// Package with shared types, constants and CORDIC arctangent table for the rotation matrix unit.
package erm_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_FRAC = 30;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef logic signed [33:0] cordic_word_t;
    typedef logic signed [32:0] cordic_angle_t;

    typedef struct packed {
        cordic_word_t  x;
        cordic_word_t  y;
        cordic_angle_t z;
        logic [1:0]    quad;
    } cordic_lane_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] sx;
        logic signed [31:0] cy;
        logic signed [31:0] sy;
        logic signed [31:0] cz;
        logic signed [31:0] sz;
    } trig_set_t;

    function automatic cordic_angle_t atan_turn(input logic [4:0] idx);
        cordic_angle_t r;
        case (idx)
            5'd0:  r = 33'sd536870912;
            5'd1:  r = 33'sd316933406;
            5'd2:  r = 33'sd167458907;
            5'd3:  r = 33'sd85004756;
            5'd4:  r = 33'sd42667331;
            5'd5:  r = 33'sd21354465;
            5'd6:  r = 33'sd10679838;
            5'd7:  r = 33'sd5340245;
            5'd8:  r = 33'sd2670163;
            5'd9:  r = 33'sd1335087;
            5'd10: r = 33'sd667544;
            5'd11: r = 33'sd333772;
            5'd12: r = 33'sd166886;
            5'd13: r = 33'sd83443;
            5'd14: r = 33'sd41722;
            5'd15: r = 33'sd20861;
            5'd16: r = 33'sd10430;
            5'd17: r = 33'sd5215;
            5'd18: r = 33'sd2608;
            5'd19: r = 33'sd1304;
            5'd20: r = 33'sd652;
            5'd21: r = 33'sd326;
            5'd22: r = 33'sd163;
            5'd23: r = 33'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/erm_front.sv =====
// Front end: pipelined CORDIC that turns three binary angles into sine and cosine.
module erm_front #(
    parameter int ANGLE_BITS = 16,
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [15:0]         in_ax,
    input  logic [15:0]         in_ay,
    input  logic [15:0]         in_az,
    input  logic                adv,
    output logic                out_valid,
    output erm_pkg::trig_set_t  out_trig
);
    import erm_pkg::*;

    localparam int NS = CORDIC_STEPS;
    localparam int SH = CORDIC_FRAC - COEFF_FRAC_BITS;
    localparam logic signed [33:0] ONE = 34'sd1 <<< COEFF_FRAC_BITS;

    cordic_lane_t lane_reg [3][NS+1];
    logic [NS:0]  vld_reg;
    trig_set_t    trig_reg;
    logic         tvld_reg;

    function automatic cordic_lane_t seed(input logic [15:0] a);
        logic [31:0] t;
        logic [31:0] am;
        cordic_lane_t l;
        am = 32'(a) & ((32'd1 << ANGLE_BITS) - 32'd1);
        t = am << (32 - ANGLE_BITS);
        l.x = CORDIC_GAIN_Q30;
        l.y = '0;
        l.z = cordic_angle_t'({3'b000, t[29:0]});
        l.quad = t[31:30];
        return l;
    endfunction

    function automatic logic signed [31:0] rsat(input cordic_word_t v);
        logic signed [33:0] r;
        r = (v + (34'sd1 <<< (SH - 1))) >>> SH;
        if (r > ONE) r = ONE;
        if (r < -ONE) r = -ONE;
        return 32'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            lane_reg[0][0] <= seed(in_ax);
            lane_reg[1][0] <= seed(in_ay);
            lane_reg[2][0] <= seed(in_az);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        for (genvar i = 0; i < NS; i++) begin : g_step
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (!lane_reg[g][i].z[32]) begin
                        lane_reg[g][i+1].x <= lane_reg[g][i].x - (lane_reg[g][i].y >>> i);
                        lane_reg[g][i+1].y <= lane_reg[g][i].y + (lane_reg[g][i].x >>> i);
                        lane_reg[g][i+1].z <= lane_reg[g][i].z - atan_turn(5'(i));
                    end else begin
                        lane_reg[g][i+1].x <= lane_reg[g][i].x + (lane_reg[g][i].y >>> i);
                        lane_reg[g][i+1].y <= lane_reg[g][i].y - (lane_reg[g][i].x >>> i);
                        lane_reg[g][i+1].z <= lane_reg[g][i].z + atan_turn(5'(i));
                    end
                    lane_reg[g][i+1].quad <= lane_reg[g][i].quad;
                end
            end
        end
    end

    logic signed [31:0] cos_v [3];
    logic signed [31:0] sin_v [3];

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            case (lane_reg[g][NS].quad)
                2'd0: begin
                    cos_v[g] = rsat(lane_reg[g][NS].x);
                    sin_v[g] = rsat(lane_reg[g][NS].y);
                end
                2'd1: begin
                    cos_v[g] = rsat(-lane_reg[g][NS].y);
                    sin_v[g] = rsat(lane_reg[g][NS].x);
                end
                2'd2: begin
                    cos_v[g] = rsat(-lane_reg[g][NS].x);
                    sin_v[g] = rsat(-lane_reg[g][NS].y);
                end
                default: begin
                    cos_v[g] = rsat(lane_reg[g][NS].y);
                    sin_v[g] = rsat(-lane_reg[g][NS].x);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            tvld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-1:0], in_valid};
            tvld_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            trig_reg.cx <= cos_v[0];
            trig_reg.sx <= sin_v[0];
            trig_reg.cy <= cos_v[1];
            trig_reg.sy <= sin_v[1];
            trig_reg.cz <= cos_v[2];
            trig_reg.sz <= sin_v[2];
        end
    end

    assign out_valid = tvld_reg;
    assign out_trig = trig_reg;
endmodule

// ===== rtl/erm_queue.sv =====
// Small FIFO between the sine/cosine front end and the matrix back end.
module erm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  erm_pkg::trig_set_t  wr_data,
    input  logic                rd_en,
    output erm_pkg::trig_set_t  rd_data,
    output logic                not_empty,
    output logic [erm_pkg::QUEUE_PTR_BITS:0] count
);
    import erm_pkg::*;

    trig_set_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wp_reg, rp_reg;
    logic [QUEUE_PTR_BITS:0]   cnt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QUEUE_PTR_BITS+1)'(wr_en) - (QUEUE_PTR_BITS+1)'(rd_en);
        end
    end

    assign rd_data = mem_reg[rp_reg];
    assign not_empty = cnt_reg != '0;
    assign count = cnt_reg;
endmodule

// ===== rtl/erm_back.sv =====
// Back end: two pipelined 3x3 matrix products with rounding and saturation.
module erm_back #(
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  erm_pkg::trig_set_t  in_trig,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_m [9]
);
    import erm_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< COEFF_FRAC_BITS;
    localparam logic signed [65:0] ONE_W = 66'sd1 <<< COEFF_FRAC_BITS;

    function automatic logic signed [31:0] rsat(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v + (66'sd1 <<< (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
        if (r > ONE_W) r = ONE_W;
        if (r < -ONE_W) r = -ONE_W;
        return 32'(r);
    endfunction

    logic adv;
    logic [3:0] vld_reg;
    trig_set_t t1_reg;
    logic signed [63:0] p1_reg [6];
    logic signed [31:0] xy_reg [9];
    logic signed [31:0] cz_reg, sz_reg;
    logic signed [63:0] p2_reg [9][2];
    logic signed [31:0] m_reg [9];

    assign adv = !vld_reg[3] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[2:0], in_valid};
    end

    // Stage 1 registers the products needed by X*Y; the rest are single terms.
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg <= in_trig;
            p1_reg[0] <= in_trig.sx * in_trig.sy;
            p1_reg[1] <= in_trig.cx * in_trig.sy;
            p1_reg[2] <= in_trig.sx * in_trig.cy;
            p1_reg[3] <= in_trig.cx * in_trig.cy;
            p1_reg[4] <= ONE * in_trig.cy;
            p1_reg[5] <= ONE * in_trig.sy;
        end
    end

    // Stage 2 rounds X*Y.
    always_ff @(posedge aclk) begin
        if (adv) begin
            xy_reg[0] <= rsat(66'(p1_reg[4]));
            xy_reg[1] <= '0;
            xy_reg[2] <= rsat(-66'(p1_reg[5]));
            xy_reg[3] <= rsat(66'(p1_reg[0]));
            xy_reg[4] <= rsat(66'(t1_reg.cx * ONE));
            xy_reg[5] <= rsat(66'(p1_reg[2]));
            xy_reg[6] <= rsat(66'(p1_reg[1]));
            xy_reg[7] <= rsat(-66'(t1_reg.sx * ONE));
            xy_reg[8] <= rsat(66'(p1_reg[3]));
            cz_reg <= t1_reg.cz;
            sz_reg <= t1_reg.sz;
        end
    end

    // Stage 3: row times Z; column 2 is the third element times one.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                p2_reg[r*3][0] <= xy_reg[r*3] * cz_reg;
                p2_reg[r*3][1] <= -(xy_reg[r*3+1] * sz_reg);
                p2_reg[r*3+1][0] <= xy_reg[r*3] * sz_reg;
                p2_reg[r*3+1][1] <= xy_reg[r*3+1] * cz_reg;
                p2_reg[r*3+2][0] <= xy_reg[r*3+2] * ONE;
                p2_reg[r*3+2][1] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                m_reg[k] <= rsat(66'(p2_reg[k][0]) + 66'(p2_reg[k][1]));
            end
        end
    end

    assign out_valid = vld_reg[3];
    always_comb begin
        for (int k = 0; k < 9; k++) out_m[k] = m_reg[k][15:0];
    end
endmodule

// ===== rtl/euler_rotation_matrix_unit.sv =====
// Top level: Euler angle to XYZ rotation matrix unit.
// Path from acceptance to m_valid: the CORDIC front end, the queue, then the back end.
// Throughput: one request per cycle unless stalled; CORDIC and multiplier stages are fully pipelined.
// The front end stalls only when the four-entry queue is full and its output register holds a request.
// Reset: synchronous active-low aresetn clears all valid bits and queue pointers.
module euler_rotation_matrix_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_angle_x,
    input  logic [15:0] s_angle_y,
    input  logic [15:0] s_angle_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_m00,
    output logic [15:0] m_m01,
    output logic [15:0] m_m02,
    output logic [15:0] m_m10,
    output logic [15:0] m_m11,
    output logic [15:0] m_m12,
    output logic [15:0] m_m20,
    output logic [15:0] m_m21,
    output logic [15:0] m_m22
);
    import erm_pkg::*;

    logic f_valid, adv, q_ne, b_ready, q_rd;
    trig_set_t f_trig, q_data;
    logic [QUEUE_PTR_BITS:0] q_cnt;
    logic [15:0] mm [9];

    // Only the output register of the front end is in flight beyond the queue.
    assign adv = (q_cnt + (QUEUE_PTR_BITS+1)'(f_valid)) <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign s_ready = adv;
    assign q_rd = q_ne && b_ready;

    erm_front #(.ANGLE_BITS(ANGLE_BITS), .COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid && s_ready),
        .in_ax(s_angle_x), .in_ay(s_angle_y), .in_az(s_angle_z),
        .adv(adv), .out_valid(f_valid), .out_trig(f_trig)
    );

    erm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(f_valid && adv), .wr_data(f_trig),
        .rd_en(q_rd), .rd_data(q_data), .not_empty(q_ne), .count(q_cnt)
    );

    erm_back #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .in_valid(q_ne), .in_trig(q_data),
        .in_ready(b_ready), .out_valid(m_valid), .out_ready(m_ready), .out_m(mm)
    );

    assign m_m00 = mm[0];
    assign m_m01 = mm[1];
    assign m_m02 = mm[2];
    assign m_m10 = mm[3];
    assign m_m11 = mm[4];
    assign m_m12 = mm[5];
    assign m_m20 = mm[6];
    assign m_m21 = mm[7];
    assign m_m22 = mm[8];

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue overflow");
    a_no_read_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd |-> q_cnt != '0) else $error("queue read while empty");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_m00)) else $error("result dropped");
endmodule

// ===== bench/euler_rotation_matrix_unit_tb.sv =====
// Self-checking testbench for the Euler angle to XYZ rotation matrix unit.
module euler_rotation_matrix_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 14;
    localparam int STEPS = 24;
    localparam longint ONE = 64'sd1 << FRAC;

    typedef struct {
        logic [15:0] m [9];
    } rot_matrix_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_angle_x = '0;
    logic [15:0] s_angle_y = '0;
    logic [15:0] s_angle_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_m00, m_m01, m_m02, m_m10, m_m11, m_m12, m_m20, m_m21, m_m22;

    rot_matrix_t expected_matrices [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;

    always #5 aclk = ~aclk;

    euler_rotation_matrix_unit uut (.*);

    function automatic longint round_sat(longint v, int s);
        longint r;
        r = v;
        if (s > 0) begin
            r = (v + (64'sd1 <<< (s - 1))) >>> s;
        end
        if (r > ONE) r = ONE;
        if (r < -ONE) r = -ONE;
        return r;
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl [STEPS] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return tbl[i];
    endfunction

    function automatic void angle_sincos(input logic [15:0] ang, output longint c,
                                         output longint s);
        logic [31:0] turn;
        longint x, y, z, dx, dy, cr, sr;
        turn = {ang, 16'h0};
        x = 652032874;
        y = 0;
        z = longint'(turn[29:0]);
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        case (turn[31:30])
            2'd0: begin cr = x; sr = y; end
            2'd1: begin cr = -y; sr = x; end
            2'd2: begin cr = -x; sr = -y; end
            default: begin cr = y; sr = -x; end
        endcase
        c = round_sat(cr, 30 - FRAC);
        s = round_sat(sr, 30 - FRAC);
    endfunction

    function automatic rot_matrix_t rotation_product(logic [15:0] ax, logic [15:0] ay,
                                                     logic [15:0] az);
        longint cx, sx, cy, sy, cz, sz, acc;
        longint mx [3][3], my [3][3], mz [3][3], mxy [3][3];
        rot_matrix_t r;
        angle_sincos(ax, cx, sx);
        angle_sincos(ay, cy, sy);
        angle_sincos(az, cz, sz);
        mx = '{'{ONE, 0, 0}, '{0, cx, sx}, '{0, -sx, cx}};
        my = '{'{cy, 0, -sy}, '{0, ONE, 0}, '{sy, 0, cy}};
        mz = '{'{cz, sz, 0}, '{-sz, cz, 0}, '{0, 0, ONE}};
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += mx[i][k] * my[k][j];
                mxy[i][j] = round_sat(acc, FRAC);
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += mxy[i][k] * mz[k][j];
                r.m[i * 3 + j] = 16'(round_sat(acc, FRAC));
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic [15:0] ax, input logic [15:0] ay,
                                input logic [15:0] az);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_angle_x <= ax;
        s_angle_y <= ay;
        s_angle_z <= az;
        expected_matrices.push_back(rotation_product(ax, ay, az));
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        logic [15:0] got [9];
        rot_matrix_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_m00, m_m01, m_m02, m_m10, m_m11, m_m12, m_m20, m_m21, m_m22};
            if (expected_matrices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result with no request pending");
            end else begin
                want = expected_matrices.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== want.m[i]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Entry m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                                     $signed(want.m[i]), $signed(got[i]));
                        end
                    end
                end
            end
        end
    end

    task automatic test_directed();
        logic [15:0] edges [10] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                    16'h2000, 16'h3FFF, 16'h4001, 16'h7FFF, 16'hAAAA};
        for (int i = 0; i < 10; i++) send_request(edges[i], 16'h0000, 16'h0000);
        for (int i = 0; i < 10; i++) send_request(edges[i], edges[(i + 3) % 10], edges[9 - i]);
        send_request(16'h5555, 16'hFFFF, 16'h4000);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) begin
                send_request(16'($urandom_range(3)) << 14, 16'($urandom), 16'($urandom));
            end else begin
                send_request(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 200;
        for (int i = 0; i < 60; i++) send_request(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400, 0, 0);
        test_random(300, 84, 0);
        test_random(300, 0, 84);
        test_random(300, 35, 35);
        test_backpressure();
        s_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_matrices.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
